/* hdl/cartridge_bank_mapper_with_line_irq_unit_macros.svh */
// Assertion macros for the cartridge bank mapper.
// Uses clk_i and rst_ni of the including module; empty when SYNTHESIS is defined.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_LINE_IRQ_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_LINE_IRQ_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CBM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CBM_ASSERT(lbl, prop, msg)
`define CBM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* hdl/cbm_pkg.sv */
// Types and constants of the cartridge bank mapper.
// No dependencies.
package cbm_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  // Low two address bits of a write in the program/IRQ window.
  typedef enum logic [1:0] {
    SEL_PRG_LOW  = 2'd0,
    SEL_PRG_HIGH = 2'd1,
    SEL_IRQ_OFF  = 2'd2,
    SEL_IRQ_ON   = 2'd3
  } sel_e;

  typedef enum logic [1:0] {
    CFG_PATTERN_MASK = 2'd0,
    CFG_PROGRAM_MASK = 2'd1
  } cfg_index_e;

  localparam logic [15:0] PATTERN_WIN_LO = 16'h6000;
  localparam logic [15:0] PATTERN_WIN_HI = 16'h6FFF;
  localparam logic [15:0] PROGRAM_WIN_END = 16'h7FFF;
  localparam logic [3:0]  LINE_LIMIT = 4'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [12:0] ppu_address;
  } in_item_t;

  typedef struct packed {
    logic        irq_line;
    logic [18:0] pattern_rom_address;
    logic [7:0]  program_bank_low;
    logic [7:0]  program_bank_high;
  } out_item_t;

  // A bank number above the mask is folded by AND, else kept.
  function automatic logic [7:0] clamp_bank(input logic [7:0] value, input logic [7:0] mask);
    clamp_bank = (value > mask) ? (value & mask) : value;
  endfunction

endpackage

/* hdl/cartridge_bank_mapper_with_line_irq_unit.sv */
// Cartridge bank mapper with end-of-line interrupt counter, top level.
// Depends on cbm_pkg and cartridge_bank_mapper_with_line_irq_unit_macros.svh.
//
//   channel | signals                              | direction
//   in      | in_valid_i, in_stall_o, in_data_i    | beat into the block
//   out     | out_valid_o, out_stall_i, out_data_o | beat out of the block
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i    | register write, no wait
//
// One beat per cycle sustained while the output is not stalled; a beat passes the input register,
// the decode and state update, and the result register before its result is offered.
// Reset clears the bank registers, the counter and the IRQ, and sets both masks to all ones.
// While a result is stalled, one more beat is taken into the input register.
`include "cartridge_bank_mapper_with_line_irq_unit_macros.svh"
module cartridge_bank_mapper_with_line_irq_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbm_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbm_pkg::out_item_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);

  logic               s1_valid_q, s1_valid_d;
  cbm_pkg::in_item_t  s1_data_q;
  logic               out_valid_q, out_valid_d;
  cbm_pkg::out_item_t out_data_q, out_data_d;

  logic [7:0] pattern_mask_q, program_mask_q;
  logic [7:0] pattern_banks_q [4];
  logic [7:0] pattern_banks_d [4];
  logic [7:0] program_banks_q [2];
  logic [7:0] program_banks_d [2];
  logic       counter_en_q, counter_en_d;
  logic [3:0] line_count_q, line_count_d;
  logic       irq_pending_q, irq_pending_d;

  logic in_accept;
  logic advance;

  assign advance    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  // Decode of the beat in the input register and the resulting state.
  always_comb begin
    logic [1:0]  sel;
    logic [1:0]  pbank;
    logic [15:0] addr;
    pattern_banks_d = pattern_banks_q;
    program_banks_d = program_banks_q;
    counter_en_d    = counter_en_q;
    line_count_d    = line_count_q;
    irq_pending_d   = irq_pending_q;
    addr            = s1_data_q.cpu_address;
    sel             = addr[1:0];
    pbank           = s1_data_q.ppu_address[12:11];
    out_data_d      = '0;

    case (s1_data_q.func)
      cbm_pkg::FUNC_WRITE: begin
        if (addr >= cbm_pkg::PATTERN_WIN_LO && addr <= cbm_pkg::PATTERN_WIN_HI) begin
          pattern_banks_d[sel] = cbm_pkg::clamp_bank(s1_data_q.write_data, pattern_mask_q);
        end else if (addr > cbm_pkg::PATTERN_WIN_HI && addr < cbm_pkg::PROGRAM_WIN_END) begin
          case (sel)
            cbm_pkg::SEL_PRG_LOW, cbm_pkg::SEL_PRG_HIGH: begin
              program_banks_d[sel[0]] =
                cbm_pkg::clamp_bank(s1_data_q.write_data, program_mask_q);
            end
            cbm_pkg::SEL_IRQ_OFF: begin
              counter_en_d  = 1'b0;
              line_count_d  = '0;
              irq_pending_d = 1'b0;
            end
            default: begin
              counter_en_d  = 1'b1;
              irq_pending_d = 1'b0;
            end
          endcase
        end
      end
      cbm_pkg::FUNC_TICK: begin
        if (counter_en_q && line_count_q < cbm_pkg::LINE_LIMIT) begin
          line_count_d = line_count_q + 4'd1;
          if (line_count_d == cbm_pkg::LINE_LIMIT) begin
            irq_pending_d = 1'b1;
          end
        end
      end
      cbm_pkg::FUNC_LOOKUP: begin
        out_data_d.pattern_rom_address = {pattern_banks_q[pbank], s1_data_q.ppu_address[10:0]};
      end
      default: begin
      end
    endcase

    out_data_d.irq_line          = irq_pending_d;
    out_data_d.program_bank_low  = program_banks_d[0];
    out_data_d.program_bank_high = program_banks_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      pattern_mask_q  <= 8'hFF;
      program_mask_q  <= 8'hFF;
      pattern_banks_q <= '{default: '0};
      program_banks_q <= '{default: '0};
      counter_en_q    <= 1'b0;
      line_count_q    <= '0;
      irq_pending_q   <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        pattern_banks_q <= pattern_banks_d;
        program_banks_q <= program_banks_d;
        counter_en_q    <= counter_en_d;
        line_count_q    <= line_count_d;
        irq_pending_q   <= irq_pending_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          cbm_pkg::CFG_PATTERN_MASK: pattern_mask_q <= cfg_data_i;
          cbm_pkg::CFG_PROGRAM_MASK: program_mask_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CBM_ASSERT_NEVER(a_count_range, line_count_q > cbm_pkg::LINE_LIMIT, "line count above limit")
  `CBM_ASSERT(a_irq_at_limit, irq_pending_q |-> line_count_q == cbm_pkg::LINE_LIMIT,
              "IRQ without full count")
  `CBM_ASSERT(a_irq_from_tick,
              $rose(irq_pending_q) |-> $past(advance) && $past(s1_data_q.func) == cbm_pkg::FUNC_TICK,
              "IRQ raised by a beat other than a tick")

endmodule

/* sim/cartridge_bank_mapper_with_line_irq_unit_tb.sv */
// Self-checking testbench for the cartridge bank mapper with line IRQ counter.
// Drives random and directed beats through the valid/stall channels and checks each
// result against a behavioral model of the mapper. Depends on cbm_pkg and the RTL top.
`timescale 1ns / 100ps

module cartridge_bank_mapper_with_line_irq_unit_tb;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned IDLE_PCT = 36;
  localparam int unsigned RX_HOLD_CYCLES = 80;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  cbm_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  cbm_pkg::out_item_t out_data_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [7:0]         cfg_data_i;

  cartridge_bank_mapper_with_line_irq_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Mapper state as the model sees it.
  logic [7:0] pat_bank [4];
  logic [7:0] prg_bank [2];
  logic [7:0] pat_mask;
  logic [7:0] prg_mask;
  logic       line_irq_on;
  logic [3:0] line_cnt;
  logic       irq_level;

  cbm_pkg::in_item_t  pending_beats [$];
  cbm_pkg::out_item_t expected_results [$];
  int        fails;
  bit        in_beat_taken;
  bit        quiet_mode;
  int        hold_req;
  int        hold_seen;
  int        hold_left;

  function automatic logic [7:0] fold_bank(logic [7:0] value, logic [7:0] mask);
    return (value > mask) ? (value & mask) : value;
  endfunction

  // Applies one beat to the mapper state and returns the result it produces.
  function automatic cbm_pkg::out_item_t mapper_step(cbm_pkg::in_item_t beat);
    cbm_pkg::out_item_t res;
    logic [1:0]         sel;
    res = '0;
    sel = beat.cpu_address[1:0];
    case (beat.func)
      cbm_pkg::FUNC_WRITE: begin
        if (beat.cpu_address >= cbm_pkg::PATTERN_WIN_LO &&
            beat.cpu_address <= cbm_pkg::PATTERN_WIN_HI) begin
          pat_bank[sel] = fold_bank(beat.write_data, pat_mask);
        end else if (beat.cpu_address > cbm_pkg::PATTERN_WIN_HI &&
                     beat.cpu_address < cbm_pkg::PROGRAM_WIN_END) begin
          case (sel)
            cbm_pkg::SEL_PRG_LOW, cbm_pkg::SEL_PRG_HIGH: begin
              prg_bank[sel[0]] = fold_bank(beat.write_data, prg_mask);
            end
            cbm_pkg::SEL_IRQ_OFF: begin
              line_irq_on = 1'b0;
              line_cnt = '0;
              irq_level = 1'b0;
            end
            default: begin
              // Enabling acknowledges the IRQ but keeps the count.
              line_irq_on = 1'b1;
              irq_level = 1'b0;
            end
          endcase
        end
      end
      cbm_pkg::FUNC_TICK: begin
        if (line_irq_on && line_cnt < cbm_pkg::LINE_LIMIT) begin
          line_cnt = line_cnt + 4'd1;
          if (line_cnt >= cbm_pkg::LINE_LIMIT) irq_level = 1'b1;
        end
      end
      cbm_pkg::FUNC_LOOKUP: begin
        res.pattern_rom_address = {pat_bank[beat.ppu_address[12:11]], beat.ppu_address[10:0]};
      end
      default: ;
    endcase
    res.irq_line = irq_level;
    res.program_bank_low = prg_bank[0];
    res.program_bank_high = prg_bank[1];
    return res;
  endfunction

  function automatic cbm_pkg::in_item_t make_beat(logic [1:0] func, logic [15:0] addr,
                                                  logic [7:0] data, logic [12:0] ppu);
    cbm_pkg::in_item_t b;
    b.func = func;
    b.cpu_address = addr;
    b.write_data = data;
    b.ppu_address = ppu;
    return b;
  endfunction

  // Mostly well-formed traffic in the decoded windows, with some raw noise.
  function automatic cbm_pkg::in_item_t random_beat();
    cbm_pkg::in_item_t b;
    int unsigned       pick;
    logic [1:0]        sel;
    int unsigned       choice;
    b = make_beat(2'($urandom), 16'($urandom), 8'($urandom), 13'($urandom));
    pick = $urandom_range(99);
    if (pick < 22) begin
      b.func = cbm_pkg::FUNC_WRITE;
      b.cpu_address = cbm_pkg::PATTERN_WIN_LO | 16'($urandom_range(0, 16'h0FFF));
    end else if (pick < 42) begin
      choice = $urandom_range(9);
      if (choice < 5) sel = (choice[0]) ? cbm_pkg::SEL_PRG_HIGH : cbm_pkg::SEL_PRG_LOW;
      else if (choice == 5) sel = cbm_pkg::SEL_IRQ_OFF;
      else sel = cbm_pkg::SEL_IRQ_ON;
      b.func = cbm_pkg::FUNC_WRITE;
      b.cpu_address = ((cbm_pkg::PATTERN_WIN_HI + 16'd1 + 16'($urandom_range(0, 16'h0FFB)))
                       & ~16'd3) | {14'd0, sel};
    end else if (pick < 77) begin
      b.func = cbm_pkg::FUNC_TICK;
    end else if (pick < 95) begin
      b.func = cbm_pkg::FUNC_LOOKUP;
    end
    return b;
  endfunction

  task automatic check_field(string name, logic [18:0] want, logic [18:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  // Result check, configuration tracking and prediction on accepted beats.
  always @(posedge clk_i) begin
    cbm_pkg::out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          cbm_pkg::CFG_PATTERN_MASK: pat_mask = cfg_data_i;
          cbm_pkg::CFG_PROGRAM_MASK: prg_mask = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("irq_line", 19'(want.irq_line), 19'(out_data_o.irq_line));
          check_field("pattern_rom_address", want.pattern_rom_address,
                      out_data_o.pattern_rom_address);
          check_field("program_bank_low", 19'(want.program_bank_low),
                      19'(out_data_o.program_bank_low));
          check_field("program_bank_high", 19'(want.program_bank_high),
                      19'(out_data_o.program_bank_high));
        end
      end
      in_beat_taken = in_valid_i && !in_stall_o;
      if (in_beat_taken) expected_results.push_back(mapper_step(in_data_i));
    end
  end

  // Sender: a beat that was not taken stays on the bus unchanged.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_beat_taken) begin
        in_valid_i <= 1'b1;
      end else if (pending_beats.size() != 0 &&
                   (quiet_mode || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_beats.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = RX_HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic write_reg(cbm_pkg::cfg_index_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  initial begin
    #1000000;
    $display("FAIL cartridge_bank_mapper_with_line_irq_unit");
    $finish;
  end

  initial begin
    logic [7:0] pat_masks [6];
    logic [7:0] prg_masks [6];
    pat_masks = '{8'h00, 8'hFF, 8'h0F, 8'h80, 8'h55, 8'($urandom)};
    prg_masks = '{8'h00, 8'hFF, 8'h3C, 8'h01, 8'hAA, 8'($urandom)};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = cbm_pkg::CFG_PATTERN_MASK;
    cfg_data_i = '0;
    pat_bank = '{default: '0};
    prg_bank = '{default: '0};
    pat_mask = 8'hFF;
    prg_mask = 8'hFF;
    line_irq_on = 1'b0;
    line_cnt = '0;
    irq_level = 1'b0;
    fails = 0;
    in_beat_taken = 1'b0;
    quiet_mode = 1'b0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: lookups at both ends, every bank register, ignored writes,
    // the counter saturating at its limit and a re-enable that raises nothing.
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_LOOKUP, 16'hFFFF, 8'hFF, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_LOOKUP, 16'h0000, 8'h00, 13'h1FFF));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h6000, 8'hFF, 13'h1FFF));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h6001, 8'h00, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h6FFE, 8'hA5, 13'h1555));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h6FFF, 8'h5A, 13'h0AAA));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h5FFF, 8'h11, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h7FFF, 8'h22, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'hFFFC, 8'h33, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h7000, 8'hFF, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h7FFD, 8'h7E, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h7003, 8'h00, 13'h0000));
    repeat (9) begin
      pending_beats.push_back(make_beat(cbm_pkg::FUNC_TICK, 16'h0000, 8'h00, 13'h0000));
    end
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h7FFB, 8'h00, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_TICK, 16'hFFFF, 8'hFF, 13'h1FFF));
    pending_beats.push_back(make_beat(FUNC_SPARE, 16'h6002, 8'hC3, 13'h1234));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_WRITE, 16'h7FFE, 8'h00, 13'h0000));
    pending_beats.push_back(make_beat(cbm_pkg::FUNC_LOOKUP, 16'h0000, 8'h00, 13'h17FF));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(cbm_pkg::CFG_PATTERN_MASK, pat_masks[ph]);
      write_reg(cbm_pkg::CFG_PROGRAM_MASK, prg_masks[ph]);
      quiet_mode = (ph == 2);
      // Starve the output for a while so the block backs up onto its input.
      if (ph == 3) hold_req++;
      repeat (100) pending_beats.push_back(random_beat());
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS cartridge_bank_mapper_with_line_irq_unit");
    end else begin
      $display("FAIL cartridge_bank_mapper_with_line_irq_unit");
    end
    $finish;
  end

endmodule
